### design/usje_pkg.sv
package usje_pkg;

    // Fixed bytes of the JSON text
    localparam logic [7:0] QUOTE   = 8'h22;
    localparam logic [7:0] BSLASH  = 8'h5c;
    localparam logic [7:0] CH_U    = 8'h75;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_B    = 8'h62;
    localparam logic [7:0] CH_F    = 8'h66;
    localparam logic [7:0] CH_N    = 8'h6e;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] HEX_LO  = 8'h57;   // 'a' - 10

    // Replacement character U+FFFD, three copies, byte 0 first
    localparam logic [8:0][7:0] REPL9 = {8'hbd, 8'hbf, 8'hef,
                                         8'hbd, 8'hbf, 8'hef,
                                         8'hbd, 8'hbf, 8'hef};

    // Result buffer: up to 16 bytes per input beat
    localparam int MAX_OUT = 16;
    localparam int IDX_W   = $clog2(MAX_OUT);
    localparam int CNT_W   = IDX_W + 1;

    // Escaped form of one ASCII byte, byte 0 first
    typedef struct packed {
        logic [5:0][7:0] bytes;
        logic [2:0]      len;
    } t_esc;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & 8'hc0) == 8'h80;
    endfunction

    // Full sequence length for a lead byte, 0 when it cannot lead
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd0;
        if (b >= 8'hc2 && b <= 8'hdf) n = 3'd2;
        else if (b >= 8'he0 && b <= 8'hef) n = 3'd3;
        else if (b >= 8'hf0 && b <= 8'hf4) n = 3'd4;
        return n;
    endfunction

    // Strict ranges for the second byte of a sequence
    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] s);
        logic ok;
        ok = is_cont(s);
        if (lead == 8'he0) ok = (s >= 8'ha0) && (s <= 8'hbf);
        else if (lead == 8'hed) ok = (s >= 8'h80) && (s <= 8'h9f);
        else if (lead == 8'hf0) ok = (s >= 8'h90) && (s <= 8'hbf);
        else if (lead == 8'hf4) ok = (s >= 8'h80) && (s <= 8'h8f);
        return ok;
    endfunction

    // Lower-case hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) c = CH_ZERO + {4'h0, n};
        else c = HEX_LO + {4'h0, n};
        return c;
    endfunction

    // JSON escape of one byte below 0x80
    function automatic t_esc escape_ascii(input logic [7:0] b);
        t_esc       e;
        logic [7:0] sc;
        e  = '0;
        sc = 8'h00;
        unique case (b)
            8'h22:   sc = QUOTE;
            8'h5c:   sc = BSLASH;
            8'h08:   sc = CH_B;
            8'h0c:   sc = CH_F;
            8'h0a:   sc = CH_N;
            8'h0d:   sc = CH_R;
            8'h09:   sc = CH_T;
            default: sc = 8'h00;
        endcase
        if (sc != 8'h00) begin
            e.bytes[0] = BSLASH;
            e.bytes[1] = sc;
            e.len      = 3'd2;
        end else if (b < 8'h20) begin
            e.bytes[0] = BSLASH;
            e.bytes[1] = CH_U;
            e.bytes[2] = CH_ZERO;
            e.bytes[3] = CH_ZERO;
            e.bytes[4] = hex_char(b[7:4]);
            e.bytes[5] = hex_char(b[3:0]);
            e.len      = 3'd6;
        end else begin
            e.bytes[0] = b;
            e.len      = 3'd1;
        end
        return e;
    endfunction

endpackage

### design/utf8_sanitizing_json_escaper.sv
// JSON string escaper with UTF-8 repair. Raw string bytes come in one per input
// beat; the string goes out as quoted JSON text, one byte per output beat, with
// an opening quote before the first byte and a closing quote (flagged on
// o_closing_quote) after the beat marked end of string. Quote, backslash and
// the usual controls get short escapes, other controls \u00xx; well-formed
// UTF-8 passes once its last byte arrives, and each byte of a bad or truncated
// sequence becomes EF BF BD. o_run_end marks the last output byte caused by an
// input beat. Each input beat is held in an input register, is expanded in
// one pass into a result buffer of up to 16 bytes, and the buffer drains
// through the single output byte port. The next beat is taken from the input
// register only once the buffer has drained, so plain text runs at one byte
// per cycle while the output is ready, and an escape or replacement holds the
// input until all its bytes are out. A beat with no byte and no end of string
// causes no output and does not load the result buffer.
module utf8_sanitizing_json_escaper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_no_byte,
    input  logic       i_end_of_string,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_closing_quote,
    output logic       o_run_end
);

    localparam int IDX_W = usje_pkg::IDX_W;
    localparam int CNT_W = usje_pkg::CNT_W;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_nob;
    logic       r_in_eos;

    // Sequence state
    logic [7:0] r_held [3];
    logic [1:0] r_held_cnt;
    logic [2:0] r_need;
    logic       r_opened;

    // Result buffer
    logic             r_out_valid;
    logic [7:0]       r_list [usje_pkg::MAX_OUT];
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_last_idx;
    logic             r_close;

    // Next values
    logic [7:0]       n_held [3];
    logic [1:0]       n_held_cnt;
    logic [2:0]       n_need;
    logic             n_opened;
    logic [7:0]       n_list [usje_pkg::MAX_OUT];
    logic [CNT_W-1:0] n_total;
    logic             n_close;

    logic drain_done;
    logic move;

    // Handshake: the input register hands over when the buffer frees up
    assign drain_done = r_out_valid && i_out_ready && (r_idx == r_last_idx);
    assign move       = r_in_valid && (!r_out_valid || drain_done);
    assign o_in_ready = !r_in_valid || move;

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_list[r_idx];
    assign o_run_end       = (r_idx == r_last_idx);
    assign o_closing_quote = r_close && (r_idx == r_last_idx);

    // Expansion of one beat: quote, held-sequence part, fresh-byte part, close
    always_comb begin
        logic             has_byte;
        logic             skip;
        logic             chk_ok;
        logic             complete;
        logic             fresh;
        logic [7:0]       b;
        logic [1:0]       h;
        logic [2:0]       lead_len;
        logic [8:0][7:0]  seg1;
        logic [3:0]       seg1_len;
        usje_pkg::t_esc   seg2;
        logic             q;
        logic [CNT_W-1:0] off1;
        logic [CNT_W-1:0] off2;
        logic [CNT_W-1:0] off3;
        logic [CNT_W-1:0] pos;

        b        = r_in_byte;
        h        = r_held_cnt;
        has_byte = !r_in_nob;
        skip     = !has_byte && !r_in_eos;
        lead_len = usje_pkg::lead_length(b);
        chk_ok   = 1'b0;
        complete = 1'b0;
        fresh    = 1'b0;
        seg1     = '0;
        seg1_len = 4'd0;
        seg2     = '0;

        n_held     = r_held;
        n_held_cnt = 2'd0;
        n_need     = 3'd0;
        n_opened   = r_opened;

        if (skip) begin
            n_held_cnt = r_held_cnt;
            n_need     = r_need;
        end else begin
            n_opened = !r_in_eos;

            // Held prefix: complete it, extend it, or reject it
            if (h != 2'd0) begin
                if (h == 2'd1)
                    chk_ok = has_byte && usje_pkg::second_ok(r_held[0], b);
                else
                    chk_ok = has_byte && usje_pkg::is_cont(b);
                complete = ({1'b0, h} + 3'd1) == r_need;
                if (chk_ok && complete) begin
                    for (int j = 0; j < 3; j++) seg1[j] = r_held[j];
                    seg1[4'(h)] = b;
                    seg1_len    = 4'(h) + 4'd1;
                end else if (chk_ok && !r_in_eos) begin
                    n_held[h]  = b;
                    n_held_cnt = h + 2'd1;
                    n_need     = r_need;
                end else begin
                    // lead and each continuation byte are replaced
                    seg1     = usje_pkg::REPL9;
                    seg1_len = {1'b0, h, 1'b0} + 4'(h);
                    fresh    = has_byte;
                end
            end else begin
                fresh = has_byte;
            end

            // Fresh byte: escape, start a sequence, or replace
            if (fresh) begin
                if (b < 8'h80) begin
                    seg2 = usje_pkg::escape_ascii(b);
                end else if (lead_len >= 3'd2 && !r_in_eos) begin
                    n_held[0]  = b;
                    n_held_cnt = 2'd1;
                    n_need     = lead_len;
                end else begin
                    seg2.bytes[2:0] = usje_pkg::REPL9[2:0];
                    seg2.len        = 3'd3;
                end
            end
        end

        if (!skip && r_in_eos) begin
            for (int j = 0; j < 3; j++) n_held[j] = 8'h00;
        end

        q       = !skip && !r_opened;
        n_close = !skip && r_in_eos;
        off1    = CNT_W'(q);
        off2    = off1 + CNT_W'(seg1_len);
        off3    = off2 + CNT_W'(seg2.len);
        n_total = off3 + CNT_W'(n_close);

        // Place the segments into the result slots
        for (int i = 0; i < usje_pkg::MAX_OUT; i++) begin
            pos = CNT_W'(i);
            if (pos < off1)
                n_list[i] = usje_pkg::QUOTE;
            else if (pos < off2)
                n_list[i] = seg1[4'(pos - off1)];
            else if (pos < off3)
                n_list[i] = seg2.bytes[3'(pos - off2)];
            else
                n_list[i] = usje_pkg::QUOTE;
        end
    end

    // Control and sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_held_cnt  <= 2'd0;
            r_need      <= 3'd0;
            r_opened    <= 1'b0;
            for (int j = 0; j < 3; j++) r_held[j] <= 8'h00;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (move) begin
                r_held     <= n_held;
                r_held_cnt <= n_held_cnt;
                r_need     <= n_need;
                r_opened   <= n_opened;
            end
            // Result buffer: load a new run or step through the current one
            if (move && n_total != '0) begin
                r_out_valid <= 1'b1;
                r_idx       <= '0;
            end else if (r_out_valid && i_out_ready) begin
                r_idx <= r_idx + 1'b1;
                if (drain_done) r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
            r_in_nob  <= i_no_byte;
            r_in_eos  <= i_end_of_string;
        end
        if (move && n_total != '0) begin
            r_list     <= n_list;
            r_last_idx <= IDX_W'(n_total - 1'b1);
            r_close    <= n_close;
        end
    end

endmodule

### design/usje_checker.sv
module usje_props (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_closing_quote,
    input logic       o_run_end
);

    logic r_after_close;
    logic out_beat;

    assign out_beat = o_out_valid && i_out_ready;

    // Tracks that the last output beat closed a string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_close <= 1'b0;
        end else if (out_beat) begin
            r_after_close <= o_closing_quote;
        end
    end

    // The beat after a closing quote opens the next string
    a_open_after_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && r_after_close) |-> (o_out_byte == usje_pkg::QUOTE && !o_closing_quote))
        else $error("string did not start with an opening quote");

    // A closing quote is a quote byte and ends the run of its input beat
    a_close_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_closing_quote) |-> (o_run_end && o_out_byte == usje_pkg::QUOTE))
        else $error("closing quote not a quote byte at run end");

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_out_byte) && $stable(o_run_end) && $stable(o_closing_quote)))
        else $error("stalled output beat changed");

    // No output without an input beat taken since reset
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(!i_rst_n) || $past(!(i_in_valid && o_in_ready) && !o_out_valid
                                  && !i_in_valid))
        |-> (!o_out_valid || $past(o_out_valid) || $past(!i_rst_n, 2) == 1'b0))
        else $error("output beat without input");

endmodule

bind utf8_sanitizing_json_escaper usje_props u_usje_props (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_out_byte      (o_out_byte),
    .o_closing_quote (o_closing_quote),
    .o_run_end       (o_run_end)
);

### bench/usje_checker.sv
module usje_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_no_byte,
    input  logic       i_end_of_string,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_closing_quote,
    input  logic       i_run_end,
    output int         o_err_cnt,
    output int         o_pending
);

    localparam logic [7:0] REPL_B0 = 8'hef;
    localparam logic [7:0] REPL_B1 = 8'hbf;
    localparam logic [7:0] REPL_B2 = 8'hbd;
    localparam int         REPORT_MAX = 100;

    typedef struct packed {
        logic [7:0] data;
        logic       closing;
        logic       run_end;
    } t_json_beat;

    // Expected output text, oldest first
    t_json_beat json_expected[$];

    // Shadow copy of the escaper state
    logic [7:0] held_seq [3];
    logic [1:0] held_cnt;
    logic [2:0] seq_need;
    logic       quote_sent;

    // Text produced by the beat being predicted
    logic [7:0] beat_text [usje_pkg::MAX_OUT];
    logic       beat_close [usje_pkg::MAX_OUT];
    int         beat_len;

    function automatic void put_byte(input logic [7:0] b, input logic cq);
        if (beat_len < usje_pkg::MAX_OUT) begin
            beat_text[beat_len]  = b;
            beat_close[beat_len] = cq;
            beat_len++;
        end
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h61 + 8'(n) - 8'd10);
    endfunction

    function automatic void put_ascii(input logic [7:0] b);
        logic [7:0] short_c;
        short_c = 8'h00;
        case (b)
            usje_pkg::QUOTE:  short_c = usje_pkg::QUOTE;
            usje_pkg::BSLASH: short_c = usje_pkg::BSLASH;
            8'h08:            short_c = usje_pkg::CH_B;
            8'h0c:            short_c = usje_pkg::CH_F;
            8'h0a:            short_c = usje_pkg::CH_N;
            8'h0d:            short_c = usje_pkg::CH_R;
            8'h09:            short_c = usje_pkg::CH_T;
            default:          short_c = 8'h00;
        endcase
        if (short_c != 8'h00) begin
            put_byte(usje_pkg::BSLASH, 1'b0);
            put_byte(short_c, 1'b0);
        end else if (b < 8'h20) begin
            put_byte(usje_pkg::BSLASH, 1'b0);
            put_byte(usje_pkg::CH_U, 1'b0);
            put_byte(usje_pkg::CH_ZERO, 1'b0);
            put_byte(usje_pkg::CH_ZERO, 1'b0);
            put_byte(hex_digit(b[7:4]), 1'b0);
            put_byte(hex_digit(b[3:0]), 1'b0);
        end else begin
            put_byte(b, 1'b0);
        end
    endfunction

    // Sequence length implied by a lead byte, 0 if it cannot start one
    function automatic int seq_len(input logic [7:0] lead);
        if (lead inside {[8'hc2:8'hdf]}) return 2;
        if (lead inside {[8'he0:8'hef]}) return 3;
        if (lead inside {[8'hf0:8'hf4]}) return 4;
        return 0;
    endfunction

    function automatic logic is_trail(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // Second byte ranges are narrowed for overlong, surrogate and out-of-range leads
    function automatic logic second_valid(input logic [7:0] lead, input logic [7:0] s);
        case (lead)
            8'he0:   return s inside {[8'ha0:8'hbf]};
            8'hed:   return s inside {[8'h80:8'h9f]};
            8'hf0:   return s inside {[8'h90:8'hbf]};
            8'hf4:   return s inside {[8'h80:8'h8f]};
            default: return is_trail(s);
        endcase
    endfunction

    function automatic void clear_state();
        for (int k = 0; k < 3; k++) held_seq[k] = 8'h00;
        held_cnt   = '0;
        seq_need   = '0;
        quote_sent = 1'b0;
    endfunction

    // Escape and sanitize one input beat, queue the text it produces
    task automatic predict_json(input logic [7:0] raw, input logic absent, input logic eos);
        logic [7:0] scan [4];
        int         n;
        int         pos;
        int         avail;
        int         need;
        int         k;
        logic       bad;
        t_json_beat jb;
        beat_len = 0;
        if (absent && !eos) return;
        if (!quote_sent) begin
            put_byte(usje_pkg::QUOTE, 1'b0);
            quote_sent = 1'b1;
        end
        n = 0;
        for (k = 0; k < int'(held_cnt); k++) begin
            scan[n] = held_seq[k];
            n++;
        end
        if (!absent) begin
            scan[n] = raw;
            n++;
        end
        held_cnt = '0;
        seq_need = '0;
        pos = 0;
        while (pos < n) begin
            avail = n - pos;
            if (scan[pos] < 8'h80) begin
                put_ascii(scan[pos]);
                pos++;
            end else begin
                need = seq_len(scan[pos]);
                bad  = (need == 0);
                for (k = 1; !bad && k < need && k < avail; k++) begin
                    if (k == 1) bad = !second_valid(scan[pos], scan[pos + 1]);
                    else bad = !is_trail(scan[pos + k]);
                end
                if (!bad && avail < need && !eos) begin
                    // valid prefix so far: park it until more bytes arrive
                    for (k = 0; k < avail; k++) held_seq[k] = scan[pos + k];
                    held_cnt = 2'(avail);
                    seq_need = 3'(need);
                    pos = n;
                end else if (bad || avail < need) begin
                    // replace the lead only, rescan what follows it
                    put_byte(REPL_B0, 1'b0);
                    put_byte(REPL_B1, 1'b0);
                    put_byte(REPL_B2, 1'b0);
                    pos++;
                end else begin
                    for (k = 0; k < need; k++) put_byte(scan[pos + k], 1'b0);
                    pos += need;
                end
            end
        end
        if (eos) begin
            put_byte(usje_pkg::QUOTE, 1'b1);
            clear_state();
        end
        for (k = 0; k < beat_len; k++) begin
            jb.data    = beat_text[k];
            jb.closing = beat_close[k];
            jb.run_end = (k == beat_len - 1);
            json_expected.insert(json_expected.size(), jb);
        end
    endtask

    function automatic void note_error();
        o_err_cnt++;
    endfunction

    // Compare outgoing beats first, then predict the incoming one
    always @(posedge i_clk) begin
        t_json_beat want;
        if (!i_rst_n) begin
            clear_state();
            json_expected.delete();
            o_err_cnt = 0;
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (json_expected.size() == 0) begin
                    if (o_err_cnt < REPORT_MAX)
                        $error("unexpected output beat: out_byte %02h", i_out_byte);
                    note_error();
                end else begin
                    want = json_expected.pop_front();
                    if (i_out_byte !== want.data) begin
                        if (o_err_cnt < REPORT_MAX)
                            $error("out_byte: expected %02h, actual %02h",
                                   want.data, i_out_byte);
                        note_error();
                    end
                    if (i_closing_quote !== want.closing) begin
                        if (o_err_cnt < REPORT_MAX)
                            $error("closing_quote: expected %0b, actual %0b",
                                   want.closing, i_closing_quote);
                        note_error();
                    end
                    if (i_run_end !== want.run_end) begin
                        if (o_err_cnt < REPORT_MAX)
                            $error("run_end: expected %0b, actual %0b",
                                   want.run_end, i_run_end);
                        note_error();
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_json(i_in_byte, i_no_byte, i_end_of_string);
            o_pending <= json_expected.size();
        end
    end

endmodule

### bench/tb_top.sv
module tb_top;

    localparam int RESET_CYCLES = 7;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 55;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    logic       i_clk;
    logic       i_rst_n         = 1'b0;
    logic       in_valid        = 1'b0;
    logic [7:0] in_byte         = 8'h00;
    logic       no_byte         = 1'b0;
    logic       end_of_string   = 1'b0;
    logic       out_ready       = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       closing_quote;
    logic       run_end;

    int         err_cnt;
    int         pend_cnt;
    int         cycles          = 0;
    int         sent_items      = 0;
    t_idle_mode idle_mode       = IDLE_NONE;
    logic       hold_req        = 1'b0;
    logic       hold_done       = 1'b0;
    logic [7:0] text_q[$];

    utf8_sanitizing_json_escaper DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_in_byte       (in_byte),
        .i_no_byte       (no_byte),
        .i_end_of_string (end_of_string),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_out_byte      (out_byte),
        .o_closing_quote (closing_quote),
        .o_run_end       (run_end)
    );

    usje_checker json_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_byte       (in_byte),
        .i_no_byte       (no_byte),
        .i_end_of_string (end_of_string),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_byte      (out_byte),
        .i_closing_quote (closing_quote),
        .i_run_end       (run_end),
        .o_err_cnt       (err_cnt),
        .o_pending       (pend_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("** utf8_sanitizing_json_escaper: FAILED **");
        $finish;
    end

    function automatic int send_idle_pct();
        case (idle_mode)
            IDLE_SEND: return 60;
            IDLE_BOTH: return 8;
            default:   return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (idle_mode)
            IDLE_RECV: return 60;
            IDLE_BOTH: return 8;
            default:   return 0;
        endcase
    endfunction

    // Output side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                out_ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(posedge i_clk);
                hold_done <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct());
            end
        end
    end

    // One input beat, with random idle cycles ahead of it
    task automatic send_beat(input logic [7:0] b, input logic nob, input logic eos);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct()) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid      <= 1'b1;
        in_byte       <= b;
        no_byte       <= nob;
        end_of_string <= eos;
        do @(posedge i_clk); while (!in_ready);
        if (!nob || eos) sent_items++;
    endtask

    // Stop offering beats and wait for all expected text to come out
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pend_cnt != 0);
    endtask

    // Append one byte to the string being built
    task automatic add_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endtask

    // Send text_q as one string; either the last byte or a flush beat ends it
    task automatic send_text(input bit flush);
        int last;
        last = text_q.size() - 1;
        for (int i = 0; i <= last; i++) begin
            if ($urandom_range(0, 99) < 4) send_beat(8'($urandom), 1'b1, 1'b0);
            send_beat(text_q[i], 1'b0, !flush && i == last);
        end
        if (flush || text_q.size() == 0) send_beat(8'($urandom), 1'b1, 1'b1);
    endtask

    // Append a well-formed sequence of len bytes, cut to its first keep bytes
    task automatic add_utf8(input int len, input int keep);
        logic [7:0] seq [4];
        case (len)
            2:       seq[0] = 8'($urandom_range(8'hc2, 8'hdf));
            3:       seq[0] = 8'($urandom_range(8'he0, 8'hef));
            default: seq[0] = 8'($urandom_range(8'hf0, 8'hf4));
        endcase
        case (seq[0])
            8'he0:   seq[1] = 8'($urandom_range(8'ha0, 8'hbf));
            8'hed:   seq[1] = 8'($urandom_range(8'h80, 8'h9f));
            8'hf0:   seq[1] = 8'($urandom_range(8'h90, 8'hbf));
            8'hf4:   seq[1] = 8'($urandom_range(8'h80, 8'h8f));
            default: seq[1] = 8'($urandom_range(8'h80, 8'hbf));
        endcase
        seq[2] = 8'($urandom_range(8'h80, 8'hbf));
        seq[3] = 8'($urandom_range(8'h80, 8'hbf));
        for (int k = 0; k < keep; k++) add_byte(seq[k]);
    endtask

    // Mostly well-formed text with some truncation, bad seconds and noise
    task automatic rand_string();
        int         n_chars;
        int         r;
        int         len;
        logic [7:0] lead;
        n_chars = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
        text_q.delete();
        for (int c = 0; c < n_chars; c++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                case ($urandom_range(0, 3))
                    0: begin
                        case ($urandom_range(0, 6))
                            0: add_byte(usje_pkg::QUOTE);
                            1: add_byte(usje_pkg::BSLASH);
                            2: add_byte(8'h08);
                            3: add_byte(8'h0c);
                            4: add_byte(8'h0a);
                            5: add_byte(8'h0d);
                            default: add_byte(8'h09);
                        endcase
                    end
                    1: add_byte(8'($urandom_range(8'h00, 8'h1f)));
                    default: add_byte(8'($urandom_range(8'h20, 8'h7f)));
                endcase
            end else if (r < 72) begin
                len = $urandom_range(2, 4);
                add_utf8(len, len);
            end else if (r < 82) begin
                len = $urandom_range(2, 4);
                add_utf8(len, $urandom_range(1, len - 1));
            end else if (r < 88) begin
                // lead with an out-of-range second byte
                case ($urandom_range(0, 3))
                    0: begin lead = 8'he0; add_byte(lead);
                       add_byte(8'($urandom_range(8'h80, 8'h9f))); end
                    1: begin lead = 8'hed; add_byte(lead);
                       add_byte(8'($urandom_range(8'ha0, 8'hbf))); end
                    2: begin lead = 8'hf0; add_byte(lead);
                       add_byte(8'($urandom_range(8'h80, 8'h8f))); end
                    default: begin lead = 8'hf4; add_byte(lead);
                       add_byte(8'($urandom_range(8'h90, 8'hbf))); end
                endcase
            end else begin
                add_byte(8'($urandom));
            end
        end
        send_text($urandom_range(0, 1) == 1);
    endtask

    task automatic rand_phase(input t_idle_mode mode);
        int target;
        idle_mode = mode;
        target = sent_items + PHASE_ITEMS;
        while (sent_items < target) rand_string();
        drain();
    endtask

    // Stimulus and verdict
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty string
        text_q.delete();
        send_text(1'b1);
        // quote, backslash, short escapes, \u00XX controls, DEL
        text_q = '{usje_pkg::QUOTE, usje_pkg::BSLASH, 8'h08, 8'h0c, 8'h0a, 8'h0d,
                   8'h09, 8'h00, 8'h1f, 8'h7f};
        send_text(1'b0);
        // longest two- and four-byte sequences
        text_q = '{8'hdf, 8'hbf, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
        send_text(1'b0);
        // early rejection of a held lead, then stray trailing bytes
        text_q = '{8'he0, 8'h80, 8'h80};
        send_text(1'b0);
        // truncated sequence flushed at end of string
        text_q = '{8'hf0, 8'h90};
        send_text(1'b1);
        // stray leads, with an empty beat in between
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'h5a, 1'b1, 1'b0);
        send_beat(8'hc0, 1'b0, 1'b1);
        drain();

        // long output hold-off while the sender keeps going
        hold_req <= 1'b1;
        rand_phase(IDLE_NONE);
        rand_phase(IDLE_SEND);
        rand_phase(IDLE_RECV);
        rand_phase(IDLE_BOTH);
        idle_mode = IDLE_NONE;
        rand_phase(IDLE_NONE);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && pend_cnt == 0)
            $display("** utf8_sanitizing_json_escaper: PASSED **");
        else
            $display("** utf8_sanitizing_json_escaper: FAILED **");
        $finish;
    end

endmodule
